@@ rtl/core/jpd_pkg.sv @@
// jpd_pkg: shared constants, payload types and the arctangent table for the
// joystick polar converter. No dependencies; every other file in rtl/core uses it.

package jpd_pkg;

   // sample and pipeline sizing
   localparam int SAMPLE_BITS       = 10;
   localparam int CORDIC_STAGES     = 16;
   localparam int TABLE_LEN         = 24;
   localparam int TAB_IDX_W         = 5;
   localparam int CORDIC_SCALE_BITS = 16;
   localparam int LEN_FRAC_SHIFT    = 8;

   // derived widths
   localparam int DIFF_W      = SAMPLE_BITS + 1;
   localparam int SQ1_W       = 2 * SAMPLE_BITS;
   localparam int SQ_W        = 2 * SAMPLE_BITS + 1;
   localparam int N_W         = SQ_W + LEN_FRAC_SHIFT;
   localparam int ISQRT_STEPS = (N_W + 1) / 2;
   localparam int XY_W        = SAMPLE_BITS + CORDIC_SCALE_BITS + 3;
   localparam int Z_W         = 24;
   localparam int NUM_CELLS   = (CORDIC_STAGES > ISQRT_STEPS) ? CORDIC_STAGES : ISQRT_STEPS;
   localparam int CELL_IDX_W  = $clog2(NUM_CELLS);

   // output formats
   localparam int LEN_W        = 15;
   localparam int ANGLE_W      = 16;
   localparam int BEND_W       = 11;
   localparam int BEND_SHIFT   = SAMPLE_BITS - 7;
   localparam int QUARTER_ACC  = 2949120;
   localparam int QZ_W         = $clog2(QUARTER_ACC + 1);
   localparam int QUARTER_Q7   = 11520;
   localparam int HALF_TURN_Q7 = 23040;
   localparam int FULL_TURN_Q7 = 46080;
   localparam int BEND_MAX     = 1024;
   localparam int ANGLE_ROUND  = 128;
   localparam int ANGLE_SHIFT  = 8;

   // register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_Y      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_RADIUS = 2'd2;
   localparam logic [SAMPLE_BITS-1:0] CENTER_RESET  = SAMPLE_BITS'(512);
   localparam logic [SAMPLE_BITS-1:0] RADIUS_RESET  = SAMPLE_BITS'(30);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_x;
      logic [SAMPLE_BITS-1:0] sample_y;
   } req_type;

   typedef struct packed {
      logic               active;
      logic [LEN_W-1:0]   length_q4;
      logic [ANGLE_W-1:0] angle_q7;
      logic [BEND_W-1:0]  bend_q10;
   } rsp_type;

   // token handed from cell to cell
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [N_W-1:0]         rem;
      logic [N_W-1:0]         root;
      logic                   neg_x;
      logic                   neg_y;
      logic                   active;
   } cell_type;

   // atan(2^-i) in 1/32768 degree
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:  val = Z_W'(1474560);
         5'd1:  val = Z_W'(870484);
         5'd2:  val = Z_W'(459940);
         5'd3:  val = Z_W'(233473);
         5'd4:  val = Z_W'(117189);
         5'd5:  val = Z_W'(58652);
         5'd6:  val = Z_W'(29333);
         5'd7:  val = Z_W'(14667);
         5'd8:  val = Z_W'(7334);
         5'd9:  val = Z_W'(3667);
         5'd10: val = Z_W'(1833);
         5'd11: val = Z_W'(917);
         5'd12: val = Z_W'(458);
         5'd13: val = Z_W'(229);
         5'd14: val = Z_W'(115);
         5'd15: val = Z_W'(57);
         5'd16: val = Z_W'(29);
         5'd17: val = Z_W'(14);
         5'd18: val = Z_W'(7);
         5'd19: val = Z_W'(4);
         5'd20: val = Z_W'(2);
         5'd21: val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/joystick_polar_deadzone.sv @@
// joystick_polar_deadzone: top level, register file and the cell chain.
// Depends on jpd_pkg, jpd_front, jpd_cell and jpd_back.
//
//   channel  handshake            payload
//   req      req_valid/req_ready  req_data   (sample_x, sample_y)
//   rsp      rsp_valid/rsp_ready  rsp_data   (active, length_q4, angle_q7, bend_q10)
//   csr      csr_we               csr_index, csr_wdata (write only)
//
// Takes one item per clock while req_ready is high; the CORDIC and square-root
// steps are unrolled into a chain of NUM_CELLS cells (16 at default sizing). An
// item passes through four front stages, the chain, and the result register.
// Reset clears every stage valid and loads the register defaults.
// Each stage holds its item while the next one is full; empty stages fill in
// under a stalled output, so req_ready drops only when the whole chain is full.

module joystick_polar_deadzone (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  jpd_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output jpd_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [jpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jpd_pkg::SAMPLE_BITS-1:0]  csr_wdata
);

   logic [jpd_pkg::SAMPLE_BITS-1:0] rest_x_ff, rest_y_ff, dead_radius_ff;

   logic              chain_valid [0:jpd_pkg::NUM_CELLS];
   logic              chain_ready [0:jpd_pkg::NUM_CELLS];
   jpd_pkg::cell_type chain_data  [0:jpd_pkg::NUM_CELLS];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rest_x_ff      <= jpd_pkg::CENTER_RESET;
         rest_y_ff      <= jpd_pkg::CENTER_RESET;
         dead_radius_ff <= jpd_pkg::RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            jpd_pkg::CSR_REST_X:      rest_x_ff      <= csr_wdata;
            jpd_pkg::CSR_REST_Y:      rest_y_ff      <= csr_wdata;
            jpd_pkg::CSR_DEAD_RADIUS: dead_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // offsets, squares and deadzone
   jpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .rest_x      (rest_x_ff),
      .rest_y      (rest_y_ff),
      .dead_radius (dead_radius_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_data     (req_data),
      .out_valid   (chain_valid[0]),
      .out_ready   (chain_ready[0]),
      .out_data    (chain_data[0])
   );

   // cell chain
   for (genvar k = 0; k < jpd_pkg::NUM_CELLS; k++) begin : g_cell
      jpd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (jpd_pkg::CELL_IDX_W'(k)),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   // angle mapping and result register
   jpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[jpd_pkg::NUM_CELLS]),
      .in_ready  (chain_ready[jpd_pkg::NUM_CELLS]),
      .in_data   (chain_data[jpd_pkg::NUM_CELLS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

@@ rtl/core/jpd_front.sv @@
// jpd_front: input capture, center offset, magnitudes, squares and deadzone test.
// Builds the first token of the cell chain. Depends on jpd_pkg.

module jpd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [jpd_pkg::SAMPLE_BITS-1:0]  rest_x,
   input  logic [jpd_pkg::SAMPLE_BITS-1:0]  rest_y,
   input  logic [jpd_pkg::SAMPLE_BITS-1:0]  dead_radius,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  jpd_pkg::req_type                 in_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output jpd_pkg::cell_type                out_data
);

   localparam int SB = jpd_pkg::SAMPLE_BITS;

   logic                            s1_vld_ff;
   jpd_pkg::req_type                s1_req_ff;
   logic                            s2_vld_ff;
   logic [SB-1:0]                   s2_mag_x_ff, s2_mag_y_ff;
   logic                            s2_neg_x_ff, s2_neg_y_ff;
   logic                            s3_vld_ff;
   logic [jpd_pkg::SQ1_W-1:0]       s3_sq_x_ff, s3_sq_y_ff, s3_rad_sq_ff;
   logic [SB-1:0]                   s3_mag_x_ff, s3_mag_y_ff;
   logic                            s3_neg_x_ff, s3_neg_y_ff;
   logic                            out_vld_ff;
   jpd_pkg::cell_type               out_data_ff;

   logic                            s2_rdy, s3_rdy, s4_rdy;
   logic [jpd_pkg::DIFF_W-1:0]      diff_x, diff_y, negd_x, negd_y;
   logic [SB-1:0]                   s2_mag_x_in, s2_mag_y_in;
   logic [jpd_pkg::SQ_W-1:0]        sum_sq;
   jpd_pkg::cell_type               out_data_in;

   // stage readiness, each stage frees when its successor moves
   assign s4_rdy   = !out_vld_ff || out_ready;
   assign s3_rdy   = !s3_vld_ff || s4_rdy;
   assign s2_rdy   = !s2_vld_ff || s3_rdy;
   assign in_ready = !s1_vld_ff || s2_rdy;

   // center offset and magnitude
   always_comb begin
      diff_x      = {1'b0, s1_req_ff.sample_x} - {1'b0, rest_x};
      diff_y      = {1'b0, s1_req_ff.sample_y} - {1'b0, rest_y};
      negd_x      = jpd_pkg::DIFF_W'(0) - diff_x;
      negd_y      = jpd_pkg::DIFF_W'(0) - diff_y;
      s2_mag_x_in = diff_x[jpd_pkg::DIFF_W-1] ? negd_x[SB-1:0] : diff_x[SB-1:0];
      s2_mag_y_in = diff_y[jpd_pkg::DIFF_W-1] ? negd_y[SB-1:0] : diff_y[SB-1:0];
   end

   // sum of squares, deadzone compare and chain token
   always_comb begin
      sum_sq             = jpd_pkg::SQ_W'(s3_sq_x_ff) + jpd_pkg::SQ_W'(s3_sq_y_ff);
      out_data_in        = '0;
      out_data_in.x      = $signed(jpd_pkg::XY_W'({s3_mag_x_ff,
                                                   {jpd_pkg::CORDIC_SCALE_BITS{1'b0}}}));
      out_data_in.y      = $signed(jpd_pkg::XY_W'({s3_mag_y_ff,
                                                   {jpd_pkg::CORDIC_SCALE_BITS{1'b0}}}));
      out_data_in.z      = '0;
      out_data_in.rem    = {sum_sq, {jpd_pkg::LEN_FRAC_SHIFT{1'b0}}};
      out_data_in.root   = '0;
      out_data_in.neg_x  = s3_neg_x_ff;
      out_data_in.neg_y  = s3_neg_y_ff;
      out_data_in.active = sum_sq >= jpd_pkg::SQ_W'(s3_rad_sq_ff);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_ready) s1_vld_ff  <= in_valid;
         if (s2_rdy)   s2_vld_ff  <= s1_vld_ff;
         if (s3_rdy)   s3_vld_ff  <= s2_vld_ff;
         if (s4_rdy)   out_vld_ff <= s3_vld_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_req_ff <= in_data;
      end
      if (s2_rdy && s1_vld_ff) begin
         s2_mag_x_ff <= s2_mag_x_in;
         s2_mag_y_ff <= s2_mag_y_in;
         s2_neg_x_ff <= diff_x[jpd_pkg::DIFF_W-1];
         s2_neg_y_ff <= diff_y[jpd_pkg::DIFF_W-1];
      end
      if (s3_rdy && s2_vld_ff) begin
         s3_sq_x_ff   <= jpd_pkg::SQ1_W'(s2_mag_x_ff) * jpd_pkg::SQ1_W'(s2_mag_x_ff);
         s3_sq_y_ff   <= jpd_pkg::SQ1_W'(s2_mag_y_ff) * jpd_pkg::SQ1_W'(s2_mag_y_ff);
         s3_rad_sq_ff <= jpd_pkg::SQ1_W'(dead_radius) * jpd_pkg::SQ1_W'(dead_radius);
         s3_mag_x_ff  <= s2_mag_x_ff;
         s3_mag_y_ff  <= s2_mag_y_ff;
         s3_neg_x_ff  <= s2_neg_x_ff;
         s3_neg_y_ff  <= s2_neg_y_ff;
      end
      if (s4_rdy && s3_vld_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;

endmodule

@@ rtl/core/jpd_cell.sv @@
// jpd_cell: one cell of the chain, one vectoring CORDIC rotation (cells below CORDIC_STAGES)
// and one square-root digit (cells below ISQRT_STEPS), registered. Depends on jpd_pkg.

module jpd_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [jpd_pkg::CELL_IDX_W-1:0]   cell_idx,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  jpd_pkg::cell_type                in_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output jpd_pkg::cell_type                out_data
);

   localparam int IDX_EXT_W = jpd_pkg::CELL_IDX_W + 1;

   logic                           valid_ff;
   jpd_pkg::cell_type              data_ff;
   jpd_pkg::cell_type              data_in;
   logic [IDX_EXT_W-1:0]           idx_ext, rev;
   logic signed [jpd_pkg::XY_W-1:0] x_cur, y_cur, xs, ys;
   logic signed [jpd_pkg::Z_W-1:0]  z_cur, angle_step;
   logic [jpd_pkg::N_W-1:0]        bit_val;
   logic [jpd_pkg::N_W:0]          trial;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      idx_ext    = {1'b0, cell_idx};
      data_in    = in_data;
      x_cur      = in_data.x;
      y_cur      = in_data.y;
      z_cur      = in_data.z;
      xs         = x_cur >>> cell_idx;
      ys         = y_cur >>> cell_idx;
      angle_step = jpd_pkg::atan_entry(jpd_pkg::TAB_IDX_W'(cell_idx));
      rev        = IDX_EXT_W'(jpd_pkg::ISQRT_STEPS - 1) - idx_ext;
      bit_val    = jpd_pkg::N_W'(1) << {rev, 1'b0};
      trial      = {1'b0, in_data.root} + {1'b0, bit_val};

      // rotate toward the x axis
      if (idx_ext < IDX_EXT_W'(jpd_pkg::CORDIC_STAGES)) begin
         if (!y_cur[jpd_pkg::XY_W-1]) begin
            data_in.x = x_cur + ys;
            data_in.y = y_cur - xs;
            data_in.z = z_cur + angle_step;
         end else begin
            data_in.x = x_cur - ys;
            data_in.y = y_cur + xs;
            data_in.z = z_cur - angle_step;
         end
      end

      // one digit of the integer square root
      if (idx_ext < IDX_EXT_W'(jpd_pkg::ISQRT_STEPS)) begin
         if ({1'b0, in_data.rem} >= trial) begin
            data_in.rem  = in_data.rem - trial[jpd_pkg::N_W-1:0];
            data_in.root = (in_data.root >> 1) + bit_val;
         end else begin
            data_in.root = in_data.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/core/jpd_back.sv @@
// jpd_back: angle rounding, quadrant mapping, bend saturation and the result
// register. Depends on jpd_pkg.

module jpd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  jpd_pkg::cell_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output jpd_pkg::rsp_type     out_data
);

   logic                              valid_ff;
   jpd_pkg::rsp_type                  data_ff;
   jpd_pkg::rsp_type                  data_in;
   logic signed [jpd_pkg::Z_W-1:0]    z_cur;
   logic [jpd_pkg::QZ_W-1:0]          z_clamp;
   logic [jpd_pkg::QZ_W:0]            z_round;
   logic [jpd_pkg::ANGLE_W-1:0]       quad_a, angle;
   logic [jpd_pkg::N_W-1:0]           bend_raw;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      // first-quadrant angle, clamped to 0..90 degrees and rounded
      z_cur = in_data.z;
      if (z_cur[jpd_pkg::Z_W-1]) begin
         z_clamp = '0;
      end else if (z_cur > jpd_pkg::Z_W'(jpd_pkg::QUARTER_ACC)) begin
         z_clamp = jpd_pkg::QZ_W'(jpd_pkg::QUARTER_ACC);
      end else begin
         z_clamp = z_cur[jpd_pkg::QZ_W-1:0];
      end
      z_round = {1'b0, z_clamp} + (jpd_pkg::QZ_W + 1)'(jpd_pkg::ANGLE_ROUND);
      quad_a  = jpd_pkg::ANGLE_W'(z_round >> jpd_pkg::ANGLE_SHIFT);
      if (quad_a > jpd_pkg::ANGLE_W'(jpd_pkg::QUARTER_Q7)) begin
         quad_a = jpd_pkg::ANGLE_W'(jpd_pkg::QUARTER_Q7);
      end

      // map into the full turn by the offset signs
      priority if (!in_data.neg_x && !in_data.neg_y) begin
         angle = quad_a;
      end else if (in_data.neg_x && !in_data.neg_y) begin
         angle = jpd_pkg::ANGLE_W'(jpd_pkg::HALF_TURN_Q7) - quad_a;
      end else if (in_data.neg_x) begin
         angle = jpd_pkg::ANGLE_W'(jpd_pkg::HALF_TURN_Q7) + quad_a;
      end else begin
         angle = jpd_pkg::ANGLE_W'(jpd_pkg::FULL_TURN_Q7) - quad_a;
      end
      if (angle >= jpd_pkg::ANGLE_W'(jpd_pkg::FULL_TURN_Q7)) begin
         angle = angle - jpd_pkg::ANGLE_W'(jpd_pkg::FULL_TURN_Q7);
      end

      // bend factor, saturated at one
      bend_raw = in_data.root >> jpd_pkg::BEND_SHIFT;

      data_in.active    = in_data.active;
      data_in.length_q4 = in_data.root[jpd_pkg::LEN_W-1:0];
      data_in.angle_q7  = in_data.active ? angle : '0;
      if (!in_data.active) begin
         data_in.bend_q10 = '0;
      end else if (bend_raw > jpd_pkg::N_W'(jpd_pkg::BEND_MAX)) begin
         data_in.bend_q10 = jpd_pkg::BEND_W'(jpd_pkg::BEND_MAX);
      end else begin
         data_in.bend_q10 = bend_raw[jpd_pkg::BEND_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
